// ===== src/ifhp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifhp_pkg
// Shared types and constants for the image frame header parser: beat
// structs, status codes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package ifhp_pkg;

	localparam int HEADER_BYTES = 64;
	localparam int HDR_AW       = $clog2(HEADER_BYTES);
	localparam int CNT_W        = 7;
	localparam logic [CNT_W-1:0] CNT_MAX  = 7'd127;
	localparam logic [CNT_W-1:0] CNT_LAST = 7'(HEADER_BYTES - 1);
	localparam logic [15:0] HDR_LEN_VAL   = 16'(HEADER_BYTES);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DW    = 32;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_W     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_H     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RGB_CODE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RGBA_CODE = 3'd6;

	// result status codes
	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_SIZE     = 4'd1;
	localparam logic [3:0] ST_MAGIC    = 4'd2;
	localparam logic [3:0] ST_VERSION  = 4'd3;
	localparam logic [3:0] ST_HDRLEN   = 4'd4;
	localparam logic [3:0] ST_FORMAT   = 4'd5;
	localparam logic [3:0] ST_FLAGS    = 4'd6;
	localparam logic [3:0] ST_DIMS     = 4'd7;
	localparam logic [3:0] ST_PAYLOAD  = 4'd8;
	localparam logic [3:0] ST_IDENTITY = 4'd9;
	localparam logic [3:0] ST_RESERVED = 4'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] format_code;
		logic [15:0] flag_bits;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [31:0] payload_size;
		logic [63:0] frame_epoch;
		logic [63:0] sequence_number;
		logic [63:0] capture_time;
		logic [63:0] reserved_first;
		logic [63:0] reserved_second;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic byte_en;   // input beat accepted
		logic wh_en;     // form width*height
		logic prod_en;   // form width*height*channels
		logic out_load;  // load result register
	} ifhp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // result register empty or draining this cycle
	} ifhp_sts_t;

endpackage

`default_nettype wire

// ===== src/ifhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifhp_ctrl
// Sequencer: collects header bytes, then steps the size product and the
// result load.
// ----------------------------------------------------------------------------
`default_nettype none

module ifhp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              last_byte,
	input  wire ifhp_pkg::ifhp_sts_t sts,
	output logic                   in_stall,
	output ifhp_pkg::ifhp_cmd_t    cmd
);

	localparam logic [1:0] S_COLLECT = 2'd0;
	localparam logic [1:0] S_MUL1    = 2'd1;
	localparam logic [1:0] S_MUL2    = 2'd2;
	localparam logic [1:0] S_FIN     = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			S_COLLECT: begin
				in_stall    = 1'b0;
				cmd.byte_en = in_valid;
				if (in_valid && last_byte) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.wh_en = 1'b1;
				state_d   = S_MUL2;
			end
			S_MUL2: begin
				cmd.prod_en = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_COLLECT;
				end
			end
			default: begin
				state_d = S_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/ifhp_dp.sv =====
// ----------------------------------------------------------------------------
// ifhp_dp
// Datapath: config registers, header byte store, byte counter, size product
// and the result register with its checks.
// ----------------------------------------------------------------------------
`default_nettype none

module ifhp_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ifhp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ifhp_pkg::CFG_DW-1:0]      cfg_data,
	input  wire ifhp_pkg::in_beat_t               in_data,
	input  wire ifhp_pkg::ifhp_cmd_t              cmd,
	input  wire logic                             out_stall,
	output ifhp_pkg::ifhp_sts_t                   sts,
	output logic                                  out_valid,
	output ifhp_pkg::out_beat_t                   out_data
);

	// config
	logic [31:0] magic_q, max_w_q, max_h_q, max_pay_q;
	logic [15:0] version_q, rgb_q, rgba_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= 32'd0;
			version_q <= 16'd1;
			max_w_q   <= 32'd4096;
			max_h_q   <= 32'd4096;
			max_pay_q <= 32'd67108864;
			rgb_q     <= 16'd1;
			rgba_q    <= 16'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ifhp_pkg::REG_MAGIC:     magic_q   <= cfg_data;
				ifhp_pkg::REG_VERSION:   version_q <= cfg_data[15:0];
				ifhp_pkg::REG_MAX_W:     max_w_q   <= cfg_data;
				ifhp_pkg::REG_MAX_H:     max_h_q   <= cfg_data;
				ifhp_pkg::REG_MAX_PAY:   max_pay_q <= cfg_data;
				ifhp_pkg::REG_RGB_CODE:  rgb_q     <= cfg_data[15:0];
				ifhp_pkg::REG_RGBA_CODE: rgba_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// byte counter and size flag
	logic [ifhp_pkg::CNT_W-1:0] cnt_q;
	logic                       size_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			size_bad_q <= 1'b0;
		end else if (cmd.byte_en) begin
			if (in_data.last_byte) begin
				cnt_q      <= '0;
				size_bad_q <= (cnt_q != ifhp_pkg::CNT_LAST);
			end else if (cnt_q != ifhp_pkg::CNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// header shift register: bytes enter at the bottom while fewer than 64
	// have come in, so byte 0 ends in the top bits and big-endian fields
	// are plain part-selects
	logic [ifhp_pkg::HEADER_BYTES*8-1:0] hdr_q;

	always_ff @(posedge clk) begin
		if (cmd.byte_en && !cnt_q[ifhp_pkg::CNT_W-1]) begin
			hdr_q <= {hdr_q[ifhp_pkg::HEADER_BYTES*8-9:0], in_data.data_byte};
		end
	end

	logic [31:0] f_magic, f_width, f_height, f_pay;
	logic [15:0] f_version, f_hlen, f_fmt, f_flags;
	logic [63:0] f_epoch, f_seq, f_time, f_res1, f_res2;

	assign f_magic   = hdr_q[511:480];
	assign f_version = hdr_q[479:464];
	assign f_hlen    = hdr_q[463:448];
	assign f_fmt     = hdr_q[447:432];
	assign f_flags   = hdr_q[431:416];
	assign f_width   = hdr_q[415:384];
	assign f_height  = hdr_q[383:352];
	assign f_pay     = hdr_q[351:320];
	assign f_epoch   = hdr_q[319:256];
	assign f_seq     = hdr_q[255:192];
	assign f_time    = hdr_q[191:128];
	assign f_res1    = hdr_q[127:64];
	assign f_res2    = hdr_q[63:0];

	// size product: width*height, then times 3 or 4 by shift-add
	logic        rgb_hit, rgba_hit;
	logic [63:0] wh_s1;
	logic [65:0] prod_s2;

	assign rgb_hit  = (f_fmt == rgb_q);
	assign rgba_hit = (f_fmt == rgba_q);

	always_ff @(posedge clk) begin
		if (cmd.wh_en) begin
			wh_s1 <= 64'(f_width) * 64'(f_height);
		end
		if (cmd.prod_en) begin
			if (rgb_hit) begin
				prod_s2 <= {1'b0, wh_s1, 1'b0} + {2'b00, wh_s1};
			end else begin
				prod_s2 <= {wh_s1, 2'b00};
			end
		end
	end

	// status, first failing check wins
	logic [3:0] st;
	logic       dims_bad;

	assign dims_bad = (f_width == 32'd0) || (f_height == 32'd0) ||
		(f_width > max_w_q) || (f_height > max_h_q) ||
		(prod_s2[65:32] != 34'd0) || (prod_s2[31:0] > max_pay_q);

	always_comb begin
		if (size_bad_q)                            st = ifhp_pkg::ST_SIZE;
		else if (f_magic != magic_q)               st = ifhp_pkg::ST_MAGIC;
		else if (f_version != version_q)           st = ifhp_pkg::ST_VERSION;
		else if (f_hlen != ifhp_pkg::HDR_LEN_VAL)  st = ifhp_pkg::ST_HDRLEN;
		else if (!rgb_hit && !rgba_hit)            st = ifhp_pkg::ST_FORMAT;
		else if (f_flags != 16'd0)                 st = ifhp_pkg::ST_FLAGS;
		else if (dims_bad)                         st = ifhp_pkg::ST_DIMS;
		else if (prod_s2[31:0] != f_pay)           st = ifhp_pkg::ST_PAYLOAD;
		else if (f_epoch == 64'd0 || f_seq == 64'd0) st = ifhp_pkg::ST_IDENTITY;
		else if (f_res1 != 64'd0 || f_res2 != 64'd0) st = ifhp_pkg::ST_RESERVED;
		else                                       st = ifhp_pkg::ST_OK;
	end

	// result register
	logic                out_valid_q;
	ifhp_pkg::out_beat_t out_q;
	logic                early_fail;

	assign early_fail = (st == ifhp_pkg::ST_SIZE) || (st == ifhp_pkg::ST_MAGIC) ||
		(st == ifhp_pkg::ST_VERSION) || (st == ifhp_pkg::ST_HDRLEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status <= st;
			if (early_fail) begin
				out_q.format_code     <= '0;
				out_q.flag_bits       <= '0;
				out_q.image_width     <= '0;
				out_q.image_height    <= '0;
				out_q.payload_size    <= '0;
				out_q.frame_epoch     <= '0;
				out_q.sequence_number <= '0;
				out_q.capture_time    <= '0;
				out_q.reserved_first  <= '0;
				out_q.reserved_second <= '0;
			end else begin
				out_q.format_code     <= f_fmt;
				out_q.flag_bits       <= f_flags;
				out_q.image_width     <= f_width;
				out_q.image_height    <= f_height;
				out_q.payload_size    <= f_pay;
				out_q.frame_epoch     <= f_epoch;
				out_q.sequence_number <= f_seq;
				out_q.capture_time    <= f_time;
				out_q.reserved_first  <= f_res1;
				out_q.reserved_second <= f_res2;
			end
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// a result is never loaded over one still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while previous one stalled");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_q.status <= ifhp_pkg::ST_RESERVED)
		else $error("status code out of range");

	a_early_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && early_fail) |=>
		(out_q.image_width == 32'd0 && out_q.frame_epoch == 64'd0))
		else $error("fields not cleared on early failure");

	a_no_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wh_en || cmd.prod_en || cmd.out_load) |-> !cmd.byte_en)
		else $error("byte taken during decode");

endmodule

`default_nettype wire

// ===== src/image_frame_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// image_frame_header_parser_top
// Parses a 64-byte big-endian image frame header, one byte per beat, and
// returns one result beat of decoded fields and status per header.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction | beat
//  --------+-----------------------------------+-----------+----------------------
//  in      | in_valid, in_stall, in_data       | in        | one header byte+last
//  out     | out_valid, out_stall, out_data    | out       | status + fields
//  cfg     | cfg_we, cfg_index, cfg_data       | in        | one register write
//
// Header bytes are taken one per cycle with no stall while collecting.
// The beat marked last starts the decode (width*height multiply, then
// channel scaling, then checks and result load); input stalls during it.
// The result register frees the decode unit as soon as it is loaded; the
// load waits only while a previous result still sits stalled on out.
// Reset is asynchronous, active low: config returns to defaults, counter
// and valids clear. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module image_frame_header_parser_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration writes
	input  wire logic                           cfg_we,
	input  wire logic [ifhp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ifhp_pkg::CFG_DW-1:0]    cfg_data,
	// header byte stream
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire ifhp_pkg::in_beat_t             in_data,
	// decoded result
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output ifhp_pkg::out_beat_t                 out_data
);

	ifhp_pkg::ifhp_cmd_t cmd;
	ifhp_pkg::ifhp_sts_t sts;

	// sequencer: byte acceptance and decode steps
	ifhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (in_data.last_byte),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	// storage, arithmetic, checks, result register
	ifhp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
